// ----- hdl/vig36_pkg.sv -----
`default_nettype none

package vig36_pkg;

    localparam int unsigned MAX_KEY_DIGITS = 16;
    localparam int unsigned SYM_COUNT      = 36;
    localparam int unsigned SYM_W          = 6;
    localparam int unsigned KEY_W          = 64;
    localparam int unsigned LEN_W          = 5;
    localparam int unsigned CFG_IDX_W      = 2;

    localparam logic [7:0] CASE_GAP = 8'h20;
    localparam logic [7:0] NEWLINE  = 8'h0A;

    typedef logic [SYM_W-1:0] t_sym;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_DIGITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

    // alphabet: a A b c C d e E f g h i j k l L m n N o O p q r s S t u v w x y z X Z \n
    function automatic logic [7:0] sym_char(input t_sym idx);
        logic [7:0] c;
        case (idx)
            6'd0:    c = 8'h61; // a
            6'd1:    c = 8'h41; // A
            6'd2:    c = 8'h62; // b
            6'd3:    c = 8'h63; // c
            6'd4:    c = 8'h43; // C
            6'd5:    c = 8'h64; // d
            6'd6:    c = 8'h65; // e
            6'd7:    c = 8'h45; // E
            6'd8:    c = 8'h66; // f
            6'd9:    c = 8'h67; // g
            6'd10:   c = 8'h68; // h
            6'd11:   c = 8'h69; // i
            6'd12:   c = 8'h6A; // j
            6'd13:   c = 8'h6B; // k
            6'd14:   c = 8'h6C; // l
            6'd15:   c = 8'h4C; // L
            6'd16:   c = 8'h6D; // m
            6'd17:   c = 8'h6E; // n
            6'd18:   c = 8'h4E; // N
            6'd19:   c = 8'h6F; // o
            6'd20:   c = 8'h4F; // O
            6'd21:   c = 8'h70; // p
            6'd22:   c = 8'h71; // q
            6'd23:   c = 8'h72; // r
            6'd24:   c = 8'h73; // s
            6'd25:   c = 8'h53; // S
            6'd26:   c = 8'h74; // t
            6'd27:   c = 8'h75; // u
            6'd28:   c = 8'h76; // v
            6'd29:   c = 8'h77; // w
            6'd30:   c = 8'h78; // x
            6'd31:   c = 8'h79; // y
            6'd32:   c = 8'h7A; // z
            6'd33:   c = 8'h58; // X
            6'd34:   c = 8'h5A; // Z
            6'd35:   c = NEWLINE;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

    // index of an already folded byte, zero for bytes outside the alphabet
    function automatic t_sym sym_index(input logic [7:0] c);
        t_sym idx;
        case (c)
            8'h61:   idx = 6'd0;
            8'h41:   idx = 6'd1;
            8'h62:   idx = 6'd2;
            8'h63:   idx = 6'd3;
            8'h43:   idx = 6'd4;
            8'h64:   idx = 6'd5;
            8'h65:   idx = 6'd6;
            8'h45:   idx = 6'd7;
            8'h66:   idx = 6'd8;
            8'h67:   idx = 6'd9;
            8'h68:   idx = 6'd10;
            8'h69:   idx = 6'd11;
            8'h6A:   idx = 6'd12;
            8'h6B:   idx = 6'd13;
            8'h6C:   idx = 6'd14;
            8'h4C:   idx = 6'd15;
            8'h6D:   idx = 6'd16;
            8'h6E:   idx = 6'd17;
            8'h4E:   idx = 6'd18;
            8'h6F:   idx = 6'd19;
            8'h4F:   idx = 6'd20;
            8'h70:   idx = 6'd21;
            8'h71:   idx = 6'd22;
            8'h72:   idx = 6'd23;
            8'h73:   idx = 6'd24;
            8'h53:   idx = 6'd25;
            8'h74:   idx = 6'd26;
            8'h75:   idx = 6'd27;
            8'h76:   idx = 6'd28;
            8'h77:   idx = 6'd29;
            8'h78:   idx = 6'd30;
            8'h79:   idx = 6'd31;
            8'h7A:   idx = 6'd32;
            8'h58:   idx = 6'd33;
            8'h5A:   idx = 6'd34;
            NEWLINE: idx = 6'd35;
            default: idx = 6'd0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/vig36_map.sv -----
`default_nettype none

// filters one byte, maps it to its symbol, shifts by the key digit, maps back
module vig36_map (
    input  wire logic [7:0] i_byte,
    input  wire logic [3:0] i_digit,
    input  wire logic       i_encrypt,
    output logic            o_keep,
    output logic [7:0]      o_byte
);

    logic                 upper;
    logic                 lower;
    logic                 own_upper;
    logic [7:0]           folded;
    vig36_pkg::t_sym      idx;
    vig36_pkg::t_sym      digit;
    vig36_pkg::t_sym      sum;
    vig36_pkg::t_sym      shifted;

    always_comb begin
        upper = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
        lower = (i_byte >= 8'h61) && (i_byte <= 8'h7A);
        case (i_byte) inside
            8'h41, 8'h43, 8'h45, 8'h4C, 8'h4E, 8'h4F, 8'h53, 8'h58, 8'h5A: own_upper = 1'b1;
            default: own_upper = 1'b0;
        endcase
    end

    assign o_keep = upper || lower || (!i_encrypt && (i_byte == vig36_pkg::NEWLINE));
    assign folded = (upper && !own_upper) ? i_byte + vig36_pkg::CASE_GAP : i_byte;
    assign idx    = vig36_pkg::sym_index(folded);
    assign digit  = {2'b00, i_digit};
    assign sum    = idx + digit;

    // modulo 36 with a single correction each way
    always_comb begin
        if (i_encrypt) begin
            shifted = (sum >= vig36_pkg::SYM_W'(vig36_pkg::SYM_COUNT))
                    ? sum - vig36_pkg::SYM_W'(vig36_pkg::SYM_COUNT) : sum;
        end else begin
            shifted = (idx >= digit) ? idx - digit
                    : idx + vig36_pkg::SYM_W'(vig36_pkg::SYM_COUNT) - digit;
        end
    end

    assign o_byte = vig36_pkg::sym_char(shifted);

endmodule

`default_nettype wire

// ----- hdl/vigenere_36_symbol_cipher.sv -----
`default_nettype none

// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_in_byte[7:0]
// output    out        o_out_valid / i_out_ready  o_out_byte[7:0]
// config    in         i_cfg_we (no wait)         i_cfg_index[1:0], i_cfg_data[63:0]
//
// one item per clock while the result register is free; a result appears in the cycle after its item is taken
// the single result register is the only register on the path; the map is one combinational pass
// items outside the alphabet are dropped with no result and no key advance
// synchronous active-low reset clears the key position and the result valid flag, and
// loads key digits 0, key length 1, encrypt
// a stalled result holds; a new item is taken in the same cycle the old one leaves
module vigenere_36_symbol_cipher #(
    parameter int unsigned MAX_KEY_DIGITS = vig36_pkg::MAX_KEY_DIGITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [7:0]                         i_in_byte,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [7:0]                              o_out_byte,
    // configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [vig36_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [vig36_pkg::KEY_W-1:0]        i_cfg_data
);

    // position never reaches the digit count, so this many bits suffice
    localparam int unsigned POS_W = (MAX_KEY_DIGITS > 1) ? $clog2(MAX_KEY_DIGITS) : 1;
    localparam int unsigned LEN_W = vig36_pkg::LEN_W;

    logic [vig36_pkg::KEY_W-1:0] r_key_digits;
    logic [LEN_W-1:0]            r_key_length;
    logic                        r_direction;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            n_pos;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [7:0]                  r_out_byte;

    logic                        in_accept;
    logic                        out_accept;
    logic [3:0]                  digit;
    logic                        keep;
    logic [7:0]                  map_byte;
    logic [LEN_W-1:0]            eff_len;
    logic [LEN_W-1:0]            next_pos;

    // result register frees up when empty or being drained this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_accept = r_out_valid && i_out_ready;

    // current key digit, four bits per position
    assign digit = r_key_digits[{r_pos, 2'b00} +: 4];

    vig36_map u_map (
        .i_byte    (i_in_byte),
        .i_digit   (digit),
        .i_encrypt (r_direction),
        .o_keep    (keep),
        .o_byte    (map_byte)
    );

    // zero length acts as one, anything above the digit count is clamped
    always_comb begin
        if (r_key_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_key_length > LEN_W'(MAX_KEY_DIGITS)) begin
            eff_len = LEN_W'(MAX_KEY_DIGITS);
        end else begin
            eff_len = r_key_length;
        end
    end

    assign next_pos = LEN_W'(r_pos) + LEN_W'(1);

    always_comb begin
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        if (out_accept) begin
            n_out_valid = 1'b0;
        end
        if (in_accept && keep) begin
            n_out_valid = 1'b1;
            // wrap also catches a position left beyond a shortened key
            n_pos = (next_pos >= eff_len) ? '0 : next_pos[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_digits <= '0;
            r_key_length <= LEN_W'(1);
            r_direction  <= 1'b1;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    vig36_pkg::REG_KEY_DIGITS: r_key_digits <= i_cfg_data;
                    vig36_pkg::REG_KEY_LENGTH: r_key_length <= i_cfg_data[LEN_W-1:0];
                    vig36_pkg::REG_DIRECTION:  r_direction  <= i_cfg_data[0];
                    default: ;  // unknown index, write ignored
                endcase
            end
        end
    end

    // payload register, loaded only with kept items
    always_ff @(posedge i_clk) begin
        if (in_accept && keep) begin
            r_out_byte <= map_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

`ifndef SYNTHESIS
    // a dropped item must not move the key position
    a_drop_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !keep && !out_accept) |=> (r_pos == $past(r_pos)))
        else $error("key position moved on a dropped item");

    // a result only appears after an item was taken
    a_valid_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_accept && keep))
        else $error("result appeared without an accepted item");

    // key position stays inside the digit store
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEN_W'(r_pos) < LEN_W'(MAX_KEY_DIGITS)))
        else $error("key position out of range");

    // every result is a letter or a newline
    a_out_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_byte >= 8'h61 && r_out_byte <= 8'h7A)
                      || (r_out_byte >= 8'h41 && r_out_byte <= 8'h5A)
                      || (r_out_byte == vig36_pkg::NEWLINE)))
        else $error("result is not an alphabet symbol");
`endif

endmodule

`default_nettype wire
